// ===== hdl/wmr_pkg.sv =====
// ----------------------------------------------------------------------------
// wmr_pkg
// Types and fixed-point constants shared by the rotation matrix pipeline.
// ----------------------------------------------------------------------------
package wmr_pkg;

  localparam int FRAC_BITS = 28;
  localparam int SUM_FRAC  = 32;
  localparam int R_FRAC    = 30;
  localparam int ACC_FRAC  = 60;

  // reduce the raw sum of squares to SUM_FRAC fraction bits
  localparam int SUM_SH  = 2 * FRAC_BITS + 4 - SUM_FRAC;
  // c_i * r back to R_FRAC fraction bits
  localparam int Q_SH    = FRAC_BITS + 2;
  // accumulator down to output fraction bits
  localparam int PK_SH   = ACC_FRAC - FRAC_BITS;

  // divisor width: 1 + s with SUM_FRAC fraction bits
  localparam int DP_W    = 65 - SUM_SH;
  // quotient width, r never exceeds one
  localparam int Q_W     = R_FRAC + 1;
  localparam int DIV_STG = Q_W;

  localparam logic [63:0] SUM_HALF = 64'd1 << (SUM_SH - 1);
  localparam logic [63:0] DP_ONE   = 64'd1 << SUM_FRAC;

  localparam logic signed [63:0] Q_HALF  = 64'sd1 <<< (Q_SH - 1);
  localparam logic signed [63:0] PK_HALF = 64'sd1 <<< (PK_SH - 1);
  localparam logic signed [63:0] ACC_ONE = 64'sd1 <<< ACC_FRAC;
  localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] param_x;
    logic signed [31:0] param_y;
    logic signed [31:0] param_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } out_t;

endpackage

// ===== hdl/wiener_milenkovic_to_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// wiener_milenkovic_to_rotation_matrix_top
// Rotation parameters to transposed direction cosine matrix, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  input     start, busy, in_data      item taken when start && !busy
//  result    out_strobe, out_data      one-cycle strobe, no back pressure
//
//  one item per cycle; results strobe in the order their items were taken
//  the pipeline is the 31-stage reciprocal divider plus eight math stages
//  busy stays low: the pipeline always advances
//  synchronous reset clears the valid bits only
// ----------------------------------------------------------------------------
module wiener_milenkovic_to_rotation_matrix_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  wmr_pkg::in_t  in_data,
  output logic          out_strobe,
  output wmr_pkg::out_t out_data
);

  localparam int DP_W = wmr_pkg::DP_W;
  localparam int Q_W  = wmr_pkg::Q_W;

  // stage 1: squares
  logic                s1_vld_r;
  logic signed [63:0]  sq_nxt [3];
  logic [63:0]         sq_r   [3];
  wmr_pkg::in_t        s1_side_r;
  // stage 2: sum of squares
  logic                s2_vld_r;
  logic [63:0]         sum_r;
  wmr_pkg::in_t        s2_side_r;
  // stage 3: divisor
  logic                s3_vld_r;
  logic [63:0]         dp_wide;
  logic [DP_W-1:0]     dp_r;
  wmr_pkg::in_t        s3_side_r;
  // divider output
  logic                dv_vld;
  logic [Q_W-1:0]      dv_quo;
  wmr_pkg::in_t        dv_side;
  // stage 4: c_i * r and e
  logic                s4_vld_r;
  logic signed [31:0]  c_in   [3];
  logic signed [31:0]  r_s;
  logic signed [63:0]  cr_r   [3];
  logic signed [32:0]  e_wide;
  logic signed [31:0]  e4_r;
  // stage 5: rounded q_i
  logic                s5_vld_r;
  logic signed [63:0]  qt     [3];
  logic signed [31:0]  q_r    [3];
  logic signed [31:0]  e5_r;
  // stage 6: products
  logic                s6_vld_r;
  logic signed [63:0]  pqq_r  [6];
  logic signed [63:0]  peq_r  [3];
  logic signed [63:0]  pee_r;
  // stage 7: sums
  logic                s7_vld_r;
  logic signed [63:0]  acc_nxt [9];
  logic signed [63:0]  acc_r   [9];
  logic signed [63:0]  ee;
  // stage 8: output
  logic                out_vld_r;
  logic signed [63:0]  pk_t    [9];
  logic signed [31:0]  pk_v    [9];
  wmr_pkg::out_t       out_r;

  assign busy = 1'b0;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= start && !busy;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= dv_vld;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      out_vld_r <= s7_vld_r;
    end
  end

  // ---------------- stages 1 to 3 ----------------
  always_comb begin
    sq_nxt[0] = 64'(in_data.param_x) * 64'(in_data.param_x);
    sq_nxt[1] = 64'(in_data.param_y) * 64'(in_data.param_y);
    sq_nxt[2] = 64'(in_data.param_z) * 64'(in_data.param_z);
    // round the sum to SUM_FRAC fraction bits, then add one
    dp_wide   = ((sum_r + wmr_pkg::SUM_HALF) >> wmr_pkg::SUM_SH) + wmr_pkg::DP_ONE;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
    s1_side_r <= in_data;
    sum_r     <= sq_r[0] + sq_r[1] + sq_r[2];
    s2_side_r <= s1_side_r;
    dp_r      <= dp_wide[DP_W-1:0];
    s3_side_r <= s2_side_r;
  end

  wmr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_dp    (dp_r),
    .in_side  (s3_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // ---------------- stages 4 and 5 ----------------
  always_comb begin
    c_in[0] = dv_side.param_x;
    c_in[1] = dv_side.param_y;
    c_in[2] = dv_side.param_z;
    r_s     = $signed({1'b0, dv_quo});
    // e = 2r - 1, equal to 2*c0*r
    e_wide  = $signed({1'b0, dv_quo, 1'b0}) - (33'sd1 <<< wmr_pkg::R_FRAC);
    for (int i = 0; i < 3; i++) begin
      qt[i] = cr_r[i];
      qt[i] = (qt[i] + wmr_pkg::Q_HALF) >>> wmr_pkg::Q_SH;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cr_r[i] <= 64'(c_in[i]) * 64'(r_s);
      q_r[i]  <= qt[i][31:0];
    end
    e4_r <= e_wide[31:0];
    e5_r <= e4_r;
  end

  // ---------------- stage 6: products ----------------
  always_ff @(posedge clk) begin
    pqq_r[0] <= 64'(q_r[0]) * 64'(q_r[0]);
    pqq_r[1] <= 64'(q_r[1]) * 64'(q_r[1]);
    pqq_r[2] <= 64'(q_r[2]) * 64'(q_r[2]);
    pqq_r[3] <= 64'(q_r[0]) * 64'(q_r[1]);
    pqq_r[4] <= 64'(q_r[0]) * 64'(q_r[2]);
    pqq_r[5] <= 64'(q_r[1]) * 64'(q_r[2]);
    for (int i = 0; i < 3; i++) begin
      peq_r[i] <= 64'(e5_r) * 64'(q_r[i]);
    end
    pee_r <= 64'(e5_r) * 64'(e5_r);
  end

  // ---------------- stage 7: entry sums ----------------
  always_comb begin
    ee         = (pee_r <<< 1) - wmr_pkg::ACC_ONE;
    acc_nxt[0] = (pqq_r[0] <<< 3) + ee;
    acc_nxt[1] = (pqq_r[3] <<< 3) - (peq_r[2] <<< 2);
    acc_nxt[2] = (pqq_r[4] <<< 3) + (peq_r[1] <<< 2);
    acc_nxt[3] = (pqq_r[3] <<< 3) + (peq_r[2] <<< 2);
    acc_nxt[4] = (pqq_r[1] <<< 3) + ee;
    acc_nxt[5] = (pqq_r[5] <<< 3) - (peq_r[0] <<< 2);
    acc_nxt[6] = (pqq_r[4] <<< 3) - (peq_r[1] <<< 2);
    acc_nxt[7] = (pqq_r[5] <<< 3) + (peq_r[0] <<< 2);
    acc_nxt[8] = (pqq_r[2] <<< 3) + ee;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      acc_r[i] <= acc_nxt[i];
    end
  end

  // ---------------- stage 8: round and saturate ----------------
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pk_t[i] = (acc_r[i] + wmr_pkg::PK_HALF) >>> wmr_pkg::PK_SH;
      if (pk_t[i] > wmr_pkg::OUT_MAX) begin
        pk_v[i] = wmr_pkg::OUT_MAX[31:0];
      end else if (pk_t[i] < wmr_pkg::OUT_MIN) begin
        pk_v[i] = wmr_pkg::OUT_MIN[31:0];
      end else begin
        pk_v[i] = pk_t[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r.m00 <= pk_v[0];
    out_r.m01 <= pk_v[1];
    out_r.m02 <= pk_v[2];
    out_r.m10 <= pk_v[3];
    out_r.m11 <= pk_v[4];
    out_r.m12 <= pk_v[5];
    out_r.m20 <= pk_v[6];
    out_r.m21 <= pk_v[7];
    out_r.m22 <= pk_v[8];
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

// ===== hdl/wmr_div.sv =====
// ----------------------------------------------------------------------------
// wmr_div
// Pipelined restoring divider for r = round(2^62 / dp), one quotient bit per
// stage, with the input parameters carried alongside each item.
// ----------------------------------------------------------------------------
module wmr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [wmr_pkg::DP_W-1:0]    in_dp,
  input  wmr_pkg::in_t                in_side,
  output logic                        out_vld,
  output logic [wmr_pkg::Q_W-1:0]     out_quo,
  output wmr_pkg::in_t                out_side
);

  localparam int DP_W = wmr_pkg::DP_W;
  localparam int Q_W  = wmr_pkg::Q_W;
  localparam int STG  = wmr_pkg::DIV_STG;
  // high part of the dividend 2^(SUM_FRAC+R_FRAC) above the quotient bits
  localparam logic [DP_W-1:0] REM_BASE =
    DP_W'(1) << (wmr_pkg::SUM_FRAC + wmr_pkg::R_FRAC - Q_W);

  logic [STG-1:0]  vld_r;
  logic [DP_W-1:0] rem_r  [STG];
  logic [DP_W-1:0] dp_r   [STG];
  logic [Q_W-1:0]  nlo_r  [STG];
  logic [Q_W-1:0]  quo_r  [STG];
  wmr_pkg::in_t    side_r [STG];

  logic [DP_W-1:0] st_rem  [STG];
  logic [DP_W-1:0] st_dp   [STG];
  logic [Q_W-1:0]  st_nlo  [STG];
  logic [Q_W-1:0]  st_quo  [STG];
  logic [DP_W:0]   st_sh   [STG];
  logic [DP_W-1:0] rem_nxt [STG];
  logic [Q_W-1:0]  quo_nxt [STG];
  logic [Q_W-1:0]  nlo_nxt [STG];

  always_comb begin
    for (int j = 0; j < STG; j++) begin
      if (j == 0) begin
        // dividend is 2^62 + dp/2: low bits come straight from dp
        st_rem[j] = REM_BASE + DP_W'(in_dp >> (Q_W + 1));
        st_dp[j]  = in_dp;
        st_nlo[j] = in_dp[Q_W:1];
        st_quo[j] = '0;
      end else begin
        st_rem[j] = rem_r[j-1];
        st_dp[j]  = dp_r[j-1];
        st_nlo[j] = nlo_r[j-1];
        st_quo[j] = quo_r[j-1];
      end
      st_sh[j]   = {st_rem[j], st_nlo[j][Q_W-1]};
      nlo_nxt[j] = st_nlo[j] << 1;
      if (st_sh[j] >= {1'b0, st_dp[j]}) begin
        rem_nxt[j] = DP_W'(st_sh[j] - {1'b0, st_dp[j]});
        quo_nxt[j] = {st_quo[j][Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[j] = st_sh[j][DP_W-1:0];
        quo_nxt[j] = {st_quo[j][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STG-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < STG; j++) begin
      rem_r[j] <= rem_nxt[j];
      dp_r[j]  <= st_dp[j];
      nlo_r[j] <= nlo_nxt[j];
      quo_r[j] <= quo_nxt[j];
      side_r[j] <= (j == 0) ? in_side : side_r[j-1];
    end
  end

  assign out_vld  = vld_r[STG-1];
  assign out_quo  = quo_r[STG-1];
  assign out_side = side_r[STG-1];

  a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> dp_r[0] >= DP_W'(wmr_pkg::DP_ONE))
    else $error("divisor below one");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STG-1] |-> rem_r[STG-1] < dp_r[STG-1])
    else $error("final remainder not below divisor");

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> out_quo <= (Q_W'(1) << wmr_pkg::R_FRAC))
    else $error("reciprocal above one");

endmodule

// ===== test/wmr_matrix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmr_matrix_checker
// Watches the parameter and matrix channels of the rotation matrix pipeline,
// predicts each matrix from the accepted parameters and compares every entry.
// ----------------------------------------------------------------------------
module wmr_matrix_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  wmr_pkg::in_t  in_data,
  input  logic          out_strobe,
  input  wmr_pkg::out_t out_data,
  output int            mismatch_total,
  output int            matrices_waiting,
  output int            matrices_seen
);

  typedef struct {
    wmr_pkg::in_t  params;
    wmr_pkg::out_t matrix;
  } expected_matrix_t;

  expected_matrix_t expected_matrices[$];
  int               bad_entries = 0;
  int               good_matrices = 0;

  // round to nearest, ties toward plus infinity
  function automatic logic signed [63:0] round_drop(input logic signed [63:0] v,
                                                    input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] entry_from_acc(input logic signed [63:0] acc);
    logic signed [63:0] v;
    v = round_drop(acc, wmr_pkg::PK_SH);
    if (v > wmr_pkg::OUT_MAX) begin
      v = wmr_pkg::OUT_MAX;
    end else if (v < wmr_pkg::OUT_MIN) begin
      v = wmr_pkg::OUT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic wmr_pkg::out_t rotation_from_params(input wmr_pkg::in_t p);
    logic signed [63:0] c [3];
    logic signed [63:0] q [3];
    logic signed [63:0] acc [9];
    logic [63:0]        sq_sum;
    logic [63:0]        sum_q32;
    logic [63:0]        divisor;
    logic [63:0]        recip;
    logic signed [63:0] e;
    logic signed [63:0] ee;
    wmr_pkg::out_t      m;
    int                 i;
    c[0] = {{32{p.param_x[31]}}, p.param_x};
    c[1] = {{32{p.param_y[31]}}, p.param_y};
    c[2] = {{32{p.param_z[31]}}, p.param_z};
    sq_sum = '0;
    for (i = 0; i < 3; i++) begin
      sq_sum = sq_sum + 64'(c[i] * c[i]);
    end
    sum_q32 = (sq_sum + wmr_pkg::SUM_HALF) >> wmr_pkg::SUM_SH;
    divisor = sum_q32 + wmr_pkg::DP_ONE;
    // 1/(1+s) with R_FRAC fraction bits, rounded
    recip = ((64'd1 << (wmr_pkg::SUM_FRAC + wmr_pkg::R_FRAC)) + divisor / 2) / divisor;
    for (i = 0; i < 3; i++) begin
      q[i] = round_drop(c[i] * $signed(recip), wmr_pkg::Q_SH);
    end
    e  = 2 * $signed(recip) - (64'sd1 <<< wmr_pkg::R_FRAC);
    ee = 2 * e * e;
    acc[0] = 8 * q[0] * q[0] + ee - wmr_pkg::ACC_ONE;
    acc[1] = 8 * q[0] * q[1] - 4 * e * q[2];
    acc[2] = 8 * q[0] * q[2] + 4 * e * q[1];
    acc[3] = 8 * q[0] * q[1] + 4 * e * q[2];
    acc[4] = 8 * q[1] * q[1] + ee - wmr_pkg::ACC_ONE;
    acc[5] = 8 * q[1] * q[2] - 4 * e * q[0];
    acc[6] = 8 * q[0] * q[2] - 4 * e * q[1];
    acc[7] = 8 * q[1] * q[2] + 4 * e * q[0];
    acc[8] = 8 * q[2] * q[2] + ee - wmr_pkg::ACC_ONE;
    // m00 sits in the top word
    for (i = 0; i < 9; i++) begin
      m[(8 - i) * 32 +: 32] = entry_from_acc(acc[i]);
    end
    return m;
  endfunction

  always @(posedge clk) begin
    expected_matrix_t head;
    logic [31:0]      want;
    logic [31:0]      got;
    int               k;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_matrices.size() == 0) begin
          if (bad_entries < 10) begin
            $display("[%0t] matrix %h with no item outstanding", $time, out_data);
          end
          bad_entries++;
        end else begin
          head = expected_matrices.pop_front();
          good_matrices++;
          for (k = 0; k < 9; k++) begin
            want = head.matrix[(8 - k) * 32 +: 32];
            got  = out_data[(8 - k) * 32 +: 32];
            if (want !== got) begin
              if (bad_entries < 10) begin
                $display("[%0t] m%0d%0d for params %h %h %h: expected %h, got %h",
                         $time, k / 3, k % 3, head.params.param_x,
                         head.params.param_y, head.params.param_z, want, got);
              end
              bad_entries++;
            end
          end
        end
      end
      if (start && !busy) begin
        expected_matrices.push_back('{params: in_data,
                                      matrix: rotation_from_params(in_data)});
      end
    end
    mismatch_total   <= bad_entries;
    matrices_waiting <= expected_matrices.size();
    matrices_seen    <= good_matrices;
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives rotation parameter sets into the rotation matrix pipeline, corner
// values first and then random full-range, unit-scale and tiny magnitudes,
// with random start gaps; the checker predicts and compares every matrix.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEMS       = 1100;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 60;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  wmr_pkg::in_t   in_data;
  logic           out_strobe;
  wmr_pkg::out_t  out_data;

  int    mismatch_total;
  int    matrices_waiting;
  int    matrices_seen;
  int    items_sent = 0;
  int    cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wiener_milenkovic_to_rotation_matrix_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  wmr_matrix_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_data          (in_data),
    .out_strobe       (out_strobe),
    .out_data         (out_data),
    .mismatch_total   (mismatch_total),
    .matrices_waiting (matrices_waiting),
    .matrices_seen    (matrices_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d matrices outstanding",
               cycles, matrices_waiting);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_params(input wmr_pkg::in_t v);
    start   <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every predicted matrix has come back
  task automatic drain_matrices();
    start <= 1'b0;
    do @(posedge clk); while (matrices_waiting != 0);
  endtask

  function automatic logic [31:0] random_param();
    logic [31:0] v;
    case ($urandom_range(0, 9)) inside
      [0:2]:   v = $urandom();
      // within plus or minus 4.0, where c is near one
      [3:5]:   v = $urandom_range(32'h7FFF_FFFF, 0) - 32'h4000_0000;
      [6:7]:   v = $urandom_range(32'h001F_FFFF, 0) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 6))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'h0000_0001;
          4:       v = 32'hFFFF_FFFF;
          5:       v = 32'h4000_0000;
          default: v = 32'hC000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int n;
    int idle_odds;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner values: zero, extremes of each field, unit and one-c magnitudes
    send_params({32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    send_params({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_params({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_params({32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF});
    send_params({32'h8000_0000, 32'h0000_0000, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h8000_0000, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h0000_0000, 32'h8000_0000});
    send_params({32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001});
    send_params({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_params({32'h1000_0000, 32'h0000_0000, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h1000_0000, 32'h0000_0000});
    send_params({32'h0000_0000, 32'h0000_0000, 32'h1000_0000});
    send_params({32'h1000_0000, 32'h1000_0000, 32'h1000_0000});
    send_params({32'h4000_0000, 32'h0000_0000, 32'h0000_0000});
    send_params({32'hC000_0000, 32'h4000_0000, 32'hC000_0000});
    send_params({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_params({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_params({32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F});
    send_params({32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333});
    drain_matrices();

    idle_odds = 0;
    for (n = 0; n < ITEMS; n++) begin
      if (n == ITEMS / 2) begin
        drain_matrices();
      end
      // idle density changes per block, some blocks run back to back
      if (n % 64 == 0) begin
        idle_odds = $urandom_range(0, 3);
      end
      if (n < ITEMS - QUIET_TAIL && $urandom_range(1, 4) <= idle_odds) begin
        hold_off($urandom_range(1, 13));
      end
      send_params({random_param(), random_param(), random_param()});
    end

    drain_matrices();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d parameter sets (corners, full range, near unit, tiny)",
             items_sent);
    $display("%0d matrices compared entry by entry, %0d bad entries",
             matrices_seen, mismatch_total);
    if (mismatch_total == 0 && matrices_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wmr_pkg.sv
hdl/wmr_div.sv
hdl/wiener_milenkovic_to_rotation_matrix_top.sv
test/wmr_matrix_checker.sv
test/tb_top.sv
